[rtl/dss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the two-stack shared array core.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int DEPTH  = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	// operation codes
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_POP     = 2'd1;
	localparam logic [1:0] OP_DUMP_HI = 2'd2;
	localparam logic [1:0] OP_DUMP_LO = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_ELEM  = 2'd3;

	typedef struct packed {
		logic [1:0]               operation;
		logic                     which_stack;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] element;
		logic                     dumped_stack;
		logic                     last;
	} rsp_t;

endpackage

[rtl/dual_stack_shared_array_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_array_core
// Two stacks sharing one word store, with push, pop and dump operations.
// ----------------------------------------------------------------------------
// Two stacks live in one store of DEPTH 32-bit words: stack one grows up from
// entry 0, stack two grows down from entry DEPTH-1. A push returns full once
// both stacks together hold DEPTH entries; a pop of an empty stack returns
// empty. A dump streams every element of the larger (op 2, tie goes to stack
// two) or smaller (op 3, tie goes to stack one) stack, last flagged on the
// final beat; stack one streams top to bottom, stack two from its top toward
// the end of the store. Push and pop each produce one beat.
// A dump reads one word a cycle, while the output register is free, from
// the single read port of the store, whose read data is registered. Input is
// held off until the final beat of the dump is in the output register, and
// only then is the next item taken.
// A result beat stalled at the output holds off the next item until it
// is taken. The store has no reset; only written entries are ever read.
module dual_stack_shared_array_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dss_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dss_pkg::rsp_t rsp
);
	import dss_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t state_q;

	// stack occupancy
	logic [CNT_W-1:0] lower_q;
	logic [CNT_W-1:0] upper_q;

	// shared word store, synchronous read
	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] rd_data_q;
	logic                     rd_en;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;

	// dump walker
	logic [ADDR_W-1:0] addr_q;     // next entry to read
	logic [CNT_W-1:0]  rem_q;      // reads still to issue
	logic              dstk_q;     // stack being dumped
	logic              rv_q;       // read data waiting to be sent
	logic              rd_last_q;  // waiting word is the final one

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic out_free;

	logic  accept;
	logic  full;
	logic  dump_sel;
	logic [CNT_W-1:0] dump_n;
	logic [CNT_W:0]   occ_sum;
	logic  load_idle;
	logic  load_dump;
	rsp_t  idle_rsp;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign occ_sum = {1'b0, lower_q} + {1'b0, upper_q};
	assign full    = occ_sum >= (CNT_W+1)'(DEPTH);

	// stack picked by a dump: larger for op 2 (tie to stack two),
	// smaller for op 3 (tie to stack one)
	always_comb begin
		if (req.operation == OP_DUMP_HI) begin
			dump_sel = !(lower_q > upper_q);
		end else begin
			dump_sel = (lower_q > upper_q);
		end
		dump_n = dump_sel ? upper_q : lower_q;
	end

	// single-beat result of an item handled in idle
	always_comb begin
		idle_rsp              = '0;
		idle_rsp.last         = 1'b1;
		wr_en                 = 1'b0;
		wr_addr               = lower_q[ADDR_W-1:0];
		case (req.operation)
			OP_PUSH: begin
				if (full) begin
					idle_rsp.status = ST_FULL;
				end else begin
					idle_rsp.status = ST_OK;
					wr_en           = accept;
					// stack two writes the entry just below its current top
					wr_addr = req.which_stack ?
						ADDR_W'(CNT_W'(DEPTH) - upper_q - CNT_W'(1)) :
						lower_q[ADDR_W-1:0];
				end
			end
			OP_POP: begin
				if (req.which_stack ? (upper_q == '0) : (lower_q == '0)) begin
					idle_rsp.status = ST_EMPTY;
				end else begin
					idle_rsp.status = ST_OK;
				end
			end
			default: begin
				// only an empty dump is answered here
				idle_rsp.status       = ST_EMPTY;
				idle_rsp.dumped_stack = dump_sel;
			end
		endcase
	end

	// a dump with elements streams from the store instead
	assign load_idle = accept &&
		!((req.operation inside {OP_DUMP_HI, OP_DUMP_LO}) && dump_n != '0);
	assign load_dump = (state_q == S_DUMP) && rv_q && out_free;
	assign rd_en     = (state_q == S_DUMP) && (rem_q != '0) && (!rv_q || out_free);

	// store: one write port for pushes, one read port for dumps
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req.push_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr_q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lower_q   <= '0;
			upper_q   <= '0;
			rem_q     <= '0;
			rv_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_idle || load_dump) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (rd_en) begin
				rv_q <= 1'b1;
			end else if (load_dump) begin
				rv_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.operation)
							OP_PUSH: begin
								if (!full) begin
									if (req.which_stack) begin
										upper_q <= upper_q + CNT_W'(1);
									end else begin
										lower_q <= lower_q + CNT_W'(1);
									end
								end
							end
							OP_POP: begin
								if (req.which_stack && upper_q != '0) begin
									upper_q <= upper_q - CNT_W'(1);
								end else if (!req.which_stack && lower_q != '0) begin
									lower_q <= lower_q - CNT_W'(1);
								end
							end
							default: begin
								if (dump_n != '0) begin
									rem_q   <= dump_n;
									state_q <= S_DUMP;
								end
							end
						endcase
					end
				end
				S_DUMP: begin
					if (rd_en) begin
						rem_q <= rem_q - CNT_W'(1);
					end
					// back to idle once the final element is in the output register
					if (load_dump && rd_last_q) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// dump walker payload
	always_ff @(posedge clk) begin
		if (accept) begin
			dstk_q <= dump_sel;
			// stack one starts at its top, stack two at its top entry
			addr_q <= dump_sel ? ADDR_W'(CNT_W'(DEPTH) - upper_q) :
				ADDR_W'(lower_q - CNT_W'(1));
		end else if (rd_en) begin
			addr_q <= dstk_q ? addr_q + ADDR_W'(1) : addr_q - ADDR_W'(1);
		end
		if (rd_en) begin
			rd_last_q <= (rem_q == CNT_W'(1));
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (load_idle) begin
			rsp_q <= idle_rsp;
		end else if (load_dump) begin
			rsp_q.status       <= ST_ELEM;
			rsp_q.element      <= rd_data_q;
			rsp_q.dumped_stack <= dstk_q;
			rsp_q.last         <= rd_last_q;
		end
	end

endmodule

[rtl/dss_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks for the two-stack shared array core.
// ----------------------------------------------------------------------------
module dss_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input dss_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input dss_pkg::rsp_t rsp
);
	import dss_pkg::*;

	// element is zero on any beat that is not a dumped element
	a_elem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_ELEM |-> rsp.element == '0)
		else $error("non-element beat carries a nonzero element");

	// ok and full beats come from push or pop: single beat, no stack tag
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_OK || rsp.status == ST_FULL)
		|-> rsp.last && !rsp.dumped_stack)
		else $error("push or pop beat malformed");

	// no new item is taken while a dump is still streaming
	a_dump_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp.status == ST_ELEM && !rsp.last |-> !req_ready)
		else $error("input accepted in the middle of a dump");

	// a stalled result beat keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// a waiting request beat keeps its payload
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request beat changed while waiting");

endmodule

bind dual_stack_shared_array_core dss_checker u_dss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-stack shared array core. A queue-fed driver
// offers push, pop and dump requests, and a clocked monitor checks each result
// beat against a cycle-free copy of both stacks. Traffic runs in phases with
// different sender and receiver idle rates, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import dss_pkg::*;

	localparam int          LONG_HOLD_CYCLES = 300;
	localparam int          TAIL_CYCLES      = 40;
	localparam int          MAX_PRINTED      = 30;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request channel
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;

	// result channel
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// traffic shaping knobs, changed only at the falling edge
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        rsp_hold       = 1'b0;
	logic        long_hold_go   = 1'b0;

	// requests not yet offered, and result beats not yet seen
	req_t req_backlog[$];
	rsp_t due_beats[$];

	// private copy of the shared store and both stack depths
	logic signed [WORD_W-1:0] mem_image [DEPTH];
	int                       bot_depth = 0;
	int                       top_depth = 0;

	int err_cnt = 0;
	int beat_no = 0;

	dual_stack_shared_array_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// generous hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic report_error(input string msg);
		if (err_cnt < MAX_PRINTED) begin
			$display("[%0t] ERROR %s", $time, msg);
		end
		err_cnt++;
	endtask

	// update the stack copy for one accepted request and queue its result beats
	task automatic apply_stack_op(input req_t r);
		rsp_t b;
		logic sel;
		int   n;
		int   idx;
		b      = '0;
		b.last = 1'b1;
		case (r.operation)
			OP_PUSH: begin
				if (bot_depth + top_depth >= DEPTH) begin
					b.status = ST_FULL;
				end else if (!r.which_stack) begin
					mem_image[ADDR_W'(bot_depth)] = r.push_value;
					bot_depth++;
					b.status = ST_OK;
				end else begin
					top_depth++;
					mem_image[ADDR_W'(DEPTH - top_depth)] = r.push_value;
					b.status = ST_OK;
				end
				due_beats.push_back(b);
			end
			OP_POP: begin
				if (!r.which_stack && bot_depth == 0) begin
					b.status = ST_EMPTY;
				end else if (r.which_stack && top_depth == 0) begin
					b.status = ST_EMPTY;
				end else begin
					if (!r.which_stack) begin
						bot_depth--;
					end else begin
						top_depth--;
					end
					b.status = ST_OK;
				end
				due_beats.push_back(b);
			end
			default: begin
				// larger stack: tie goes to stack two; smaller stack: tie goes to stack one
				if (r.operation == OP_DUMP_HI) begin
					sel = !(bot_depth > top_depth);
				end else begin
					sel = (bot_depth > top_depth);
				end
				n              = sel ? top_depth : bot_depth;
				b.dumped_stack = sel;
				if (n == 0) begin
					b.status = ST_EMPTY;
					due_beats.push_back(b);
				end else begin
					for (int i = 0; i < n; i++) begin
						// stack one walks down from its top, stack two walks up to the end
						idx       = sel ? (DEPTH - top_depth + i) : (bot_depth - 1 - i);
						b.status  = ST_ELEM;
						b.element = mem_image[ADDR_W'(idx)];
						b.last    = (i == n - 1);
						due_beats.push_back(b);
					end
				end
			end
		endcase
	endtask

	// driver: predicts on every accepted beat, then offers the next backlog entry
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready) begin
				apply_stack_op(req);
			end
			// valid holds with a stable payload until the beat is taken
			if (!req_valid || req_ready) begin
				if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: every taken result beat must match the oldest outstanding one
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_beats.size() == 0) begin
					report_error($sformatf("beat %0d arrived with nothing outstanding", beat_no));
				end else begin
					want = due_beats.pop_front();
					if (rsp.status !== want.status)
						report_error($sformatf("beat %0d status: got %0d, want %0d",
							beat_no, rsp.status, want.status));
					if (rsp.element !== want.element)
						report_error($sformatf("beat %0d element: got %0d, want %0d",
							beat_no, rsp.element, want.element));
					if (rsp.dumped_stack !== want.dumped_stack)
						report_error($sformatf("beat %0d dumped_stack: got %0b, want %0b",
							beat_no, rsp.dumped_stack, want.dumped_stack));
					if (rsp.last !== want.last)
						report_error($sformatf("beat %0d last: got %0b, want %0b",
							beat_no, rsp.last, want.last));
				end
				beat_no++;
			end
			rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long output hold-off, counted here so the sender keeps pushing meanwhile
	initial begin
		wait (long_hold_go);
		rsp_hold = 1'b1;
		repeat (LONG_HOLD_CYCLES) @(negedge clk);
		rsp_hold = 1'b0;
	end

	task automatic queue_op(input logic [1:0] op, input logic stk, input logic [31:0] val);
		req_t r;
		r.operation   = op;
		r.which_stack = stk;
		r.push_value  = val;
		req_backlog.push_back(r);
	endtask

	// weighted random requests; whatever is not push or pop is a dump
	task automatic queue_random(input int n, input int push_w, input int pop_w);
		int          pick;
		logic [31:0] val;
		logic [1:0]  op;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < push_w)
				op = OP_PUSH;
			else if (pick < push_w + pop_w)
				op = OP_POP;
			else
				op = $urandom_range(1) ? OP_DUMP_HI : OP_DUMP_LO;
			// mix in the word extremes now and then
			case ($urandom_range(15))
				0:       val = 32'h8000_0000;
				1:       val = 32'h7fff_ffff;
				2:       val = 32'h0000_0000;
				3:       val = 32'hffff_ffff;
				default: val = $urandom;
			endcase
			queue_op(op, 1'($urandom_range(1)), val);
		end
	endtask

	// sender pause: wait, at a settled point, until every beat has come back
	task automatic drain();
		while (req_backlog.size() != 0 || req_valid || due_beats.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty stacks, word extremes, tie breaks, dump order
		queue_op(OP_POP,     1'b0, 32'h0);
		queue_op(OP_POP,     1'b1, 32'h0);
		queue_op(OP_DUMP_HI, 1'b0, 32'h0);
		queue_op(OP_DUMP_LO, 1'b1, 32'h0);
		queue_op(OP_PUSH,    1'b0, 32'h8000_0000);
		queue_op(OP_PUSH,    1'b0, 32'h7fff_ffff);
		queue_op(OP_PUSH,    1'b1, 32'hffff_ffff);
		queue_op(OP_DUMP_HI, 1'b1, 32'h0);
		queue_op(OP_DUMP_LO, 1'b0, 32'h0);
		queue_op(OP_PUSH,    1'b1, 32'h0000_0000);
		queue_op(OP_DUMP_HI, 1'b0, 32'h0);
		queue_op(OP_DUMP_LO, 1'b1, 32'h0);
		queue_op(OP_POP,     1'b0, 32'hffff_ffff);
		queue_op(OP_POP,     1'b1, 32'hffff_ffff);
		queue_op(OP_DUMP_LO, 1'b1, 32'h0);
		queue_op(OP_POP,     1'b0, 32'h0);
		queue_op(OP_DUMP_LO, 1'b0, 32'h0);
		queue_op(OP_DUMP_HI, 1'b1, 32'h0);
		queue_op(OP_POP,     1'b1, 32'h0);
		queue_op(OP_POP,     1'b1, 32'h0);
		drain();

		// pressure: outputs held off while a push burst runs into a full store,
		// then full-size dumps of both stacks and a pop-down
		long_hold_go = 1'b1;
		queue_random(44, 100, 0);
		queue_op(OP_DUMP_HI, 1'b0, 32'h0);
		queue_op(OP_DUMP_LO, 1'b1, 32'h0);
		queue_random(20, 0, 100);
		drain();

		// random phases: no idling, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			// fill toward full, then pop down, then a balanced mix
			queue_random(35, 70, 15);
			queue_random(20, 15, 60);
			drain();
			queue_random(40, 55, 25);
			drain();
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		drain();
		// stray beats after the last expected one show up in the monitor
		repeat (TAIL_CYCLES) @(negedge clk);
		if (due_beats.size() != 0)
			report_error($sformatf("%0d result beats never arrived", due_beats.size()));
		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
